// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int CMD_W    = 2;
    localparam int WHERE_W  = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [WHERE_W-1:0] WHERE_FRONT = 2'd0;
    localparam logic [WHERE_W-1:0] WHERE_BACK  = 2'd1;
    localparam logic [WHERE_W-1:0] WHERE_AT    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic insert_en;
        logic delete_en;
    } ple_shift_t;

endpackage

// ===== rtl/ple_cell.sv =====
module ple_cell #(
    parameter int INDEX = 0,
    parameter int AW    = 4,
    parameter int DW    = ple_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                aclk,
    input  ple_pkg::ple_shift_t ctrl,
    input  logic [AW-1:0]       target,
    input  logic [DW-1:0]       word,
    input  logic [DW-1:0]       prev_data,
    input  logic [DW-1:0]       next_data,
    output logic [DW-1:0]       data_out,
    output logic [DW-1:0]       rd_out
);

    localparam logic [AW-1:0] IDX = AW'(INDEX);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.insert_en) begin
            if (IDX > target) begin
                data_next = prev_data;
            end else if (IDX == target) begin
                data_next = word;
            end
        end else if (ctrl.delete_en) begin
            if (IDX >= target) begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign rd_out   = (IDX == target) ? data_reg : '0;

endmodule

// ===== rtl/positional_list_engine.sv =====
// positional list engine: an ordered list of up to DEPTH words kept in a row of cells
// input channel s_*: one command per transfer (insert, delete or read)
// output channel m_*: exactly one result per command (status, read data, count)
// result: registered, it shows in the cycle after the input transfer
// throughput: one command per cycle unless a result waits on m_tready; every cell
// compares its own index with the target position and shifts from its neighbour in the same cycle
// a read selects the addressed cell through a one-hot or of all cells
// reset: the list is emptied (count zero), no result pending; cell contents are
// left as they are and are never read before being written
// stall: while a result waits with m_tready low, s_tready is low and nothing moves;
// s_tready is high whenever the output register is empty or being taken
// status codes: 0 ok, 1 ignored, 2 full, 3 read out of range
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], where[3:2], position[8:4], value[40:9], zero fill
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], read_data[33:2], count[38:34], zero fill
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
    localparam int XW = (DATA_WIDTH > ple_pkg::VALUE_W) ? DATA_WIDTH : ple_pkg::VALUE_W;

    logic [ple_pkg::CMD_W-1:0]    cmd;
    logic [ple_pkg::WHERE_W-1:0]  where_sel;
    logic [ple_pkg::POS_W-1:0]    position;
    logic [ple_pkg::VALUE_W-1:0]  value;
    logic                         s_fire;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         m_tvalid_reg;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0]                cnt_p;
    logic [PW-1:0]                pos_p;
    logic [PW-1:0]                p;
    logic [PW-1:0]                tgt_p;
    logic [ple_pkg::STATUS_W-1:0] status;
    logic                         insert_ok;
    logic                         delete_ok;
    logic                         read_ok;

    logic [XW-1:0]                word_ext;
    logic [DATA_WIDTH-1:0]        word;
    logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]        cell_rd   [DEPTH];
    logic [DATA_WIDTH-1:0]        rd_any;
    logic [XW-1:0]                rd_ext;
    logic [ple_pkg::RDATA_W-1:0]  read_data;
    logic [PW-1:0]                count_ext;
    ple_pkg::ple_shift_t          shift;

    assign cmd       = s_tdata[1:0];
    assign where_sel = s_tdata[3:2];
    assign position  = s_tdata[8:4];
    assign value     = s_tdata[40:9];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign cnt_p = PW'(count_reg);
    assign pos_p = PW'(position);

    always_comb begin
        status     = ple_pkg::ST_IGNORED;
        insert_ok  = 1'b0;
        delete_ok  = 1'b0;
        read_ok    = 1'b0;
        p          = '0;
        tgt_p      = '0;
        count_next = count_reg;
        case (cmd)
            ple_pkg::CMD_INSERT: begin
                case (where_sel)
                    ple_pkg::WHERE_FRONT: p = PW'(1);
                    ple_pkg::WHERE_BACK:  p = cnt_p + PW'(1);
                    ple_pkg::WHERE_AT:    p = pos_p;
                    default:              p = '0;
                endcase
                if (p == '0 || p > cnt_p + PW'(1)) begin
                    status = ple_pkg::ST_IGNORED;
                end else if (count_reg == CW'(DEPTH)) begin
                    status = ple_pkg::ST_FULL;
                end else begin
                    status     = ple_pkg::ST_OK;
                    insert_ok  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                tgt_p = p - PW'(1);
            end
            ple_pkg::CMD_DELETE: begin
                case (where_sel)
                    ple_pkg::WHERE_FRONT: p = PW'(1);
                    ple_pkg::WHERE_BACK:  p = cnt_p;
                    ple_pkg::WHERE_AT:    p = pos_p;
                    default:              p = '0;
                endcase
                if (count_reg == '0 || p == '0 || p > cnt_p) begin
                    status = ple_pkg::ST_IGNORED;
                end else begin
                    status     = ple_pkg::ST_OK;
                    delete_ok  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                tgt_p = p - PW'(1);
            end
            ple_pkg::CMD_READ: begin
                tgt_p = pos_p;
                if (pos_p < cnt_p) begin
                    status  = ple_pkg::ST_OK;
                    read_ok = 1'b1;
                end else begin
                    status = ple_pkg::ST_RANGE;
                end
            end
            default: begin
                status = ple_pkg::ST_IGNORED;
            end
        endcase
    end

    assign shift.insert_en = s_fire && insert_ok;
    assign shift.delete_en = s_fire && delete_ok;

    assign word_ext = XW'(value);
    assign word     = word_ext[DATA_WIDTH-1:0];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;
        if (i == 0) begin : g_first
            assign prev_d = word;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_d = cell_data[i];
        end else begin : g_inner
            assign next_d = cell_data[i+1];
        end
        ple_cell #(
            .INDEX (i),
            .AW    (AW),
            .DW    (DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (shift),
            .target    (tgt_p[AW-1:0]),
            .word      (word),
            .prev_data (prev_d),
            .next_data (next_d),
            .data_out  (cell_data[i]),
            .rd_out    (cell_rd[i])
        );
    end

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign rd_ext    = read_ok ? XW'(rd_any) : '0;
    assign read_data = rd_ext[ple_pkg::RDATA_W-1:0];
    assign count_ext = PW'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {1'b0, count_ext[ple_pkg::COUNT_W-1:0], read_data, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("list count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && insert_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && delete_ok) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the list");

    a_reject_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && status != ple_pkg::ST_OK) |=> $stable(count_reg))
        else $error("rejected command changed the count");

    a_count_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (m_tdata_reg[38:34] == $past(count_ext[ple_pkg::COUNT_W-1:0])))
        else $error("reported count differs from the list count");

endmodule

// ===== tb/positional_list_engine_tb.sv =====
module positional_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = ple_pkg::DEPTH_DEFAULT;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 5;

    typedef logic [ple_pkg::CMD_W-1:0]   cmd_t;
    typedef logic [ple_pkg::WHERE_W-1:0] where_t;
    typedef logic [ple_pkg::POS_W-1:0]   pos_t;

    localparam cmd_t   CMD_UNUSED   = 2'd3;
    localparam where_t WHERE_UNUSED = 2'd3;

    typedef struct packed {
        logic [ple_pkg::STATUS_W-1:0] status;
        logic [ple_pkg::RDATA_W-1:0]  read_data;
        logic [ple_pkg::COUNT_W-1:0]  count;
    } list_answer_t;

    // shadow copy of the list, one answer per command
    class list_mirror;
        logic [ple_pkg::VALUE_W-1:0] cells [LIST_DEPTH];
        int                          fill;
        list_answer_t                pending_answers [$];
        int unsigned                 mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function void flag(string msg);
            if (mismatches < 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endfunction

        function void note_command(input logic [ple_pkg::S_TDATA_W-1:0] word);
            cmd_t                        op;
            where_t                      loc;
            pos_t                        idx;
            logic [ple_pkg::VALUE_W-1:0] value;
            int                          target;
            int                          i;
            list_answer_t                ans;
            op            = word[1:0];
            loc           = word[3:2];
            idx           = word[8:4];
            value         = word[40:9];
            ans.status    = ple_pkg::ST_OK;
            ans.read_data = '0;
            target        = -1;
            case (op)
                ple_pkg::CMD_INSERT: begin
                    if (loc == ple_pkg::WHERE_FRONT) begin
                        target = 1;
                    end else if (loc == ple_pkg::WHERE_BACK) begin
                        target = fill + 1;
                    end else if (loc == ple_pkg::WHERE_AT) begin
                        target = int'(idx);
                    end
                    if (target < 1 || target > fill + 1) begin
                        ans.status = ple_pkg::ST_IGNORED;
                    end else if (fill >= LIST_DEPTH) begin
                        ans.status = ple_pkg::ST_FULL;
                    end else begin
                        for (i = fill; i >= target; i--) begin
                            cells[i] = cells[i-1];
                        end
                        cells[target-1] = value;
                        fill++;
                    end
                end
                ple_pkg::CMD_DELETE: begin
                    if (fill != 0) begin
                        if (loc == ple_pkg::WHERE_FRONT) begin
                            target = 1;
                        end else if (loc == ple_pkg::WHERE_BACK) begin
                            target = fill;
                        end else if (loc == ple_pkg::WHERE_AT) begin
                            target = int'(idx);
                        end
                    end
                    if (target < 1 || target > fill) begin
                        ans.status = ple_pkg::ST_IGNORED;
                    end else begin
                        for (i = target; i < fill; i++) begin
                            cells[i-1] = cells[i];
                        end
                        fill--;
                    end
                end
                ple_pkg::CMD_READ: begin
                    if (int'(idx) < fill) begin
                        ans.read_data = cells[idx];
                    end else begin
                        ans.status = ple_pkg::ST_RANGE;
                    end
                end
                default: begin
                    ans.status = ple_pkg::ST_IGNORED;
                end
            endcase
            ans.count = fill[ple_pkg::COUNT_W-1:0];
            pending_answers.push_back(ans);
        endfunction

        function void check_result(input logic [ple_pkg::M_TDATA_W-1:0] word);
            list_answer_t got;
            list_answer_t want;
            got.status    = word[1:0];
            got.read_data = word[33:2];
            got.count     = word[38:34];
            if (pending_answers.size() == 0) begin
                flag($sformatf("result with nothing outstanding: status %0d data %h count %0d",
                               got.status, got.read_data, got.count));
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status || got.read_data !== want.read_data ||
                    got.count !== want.count) begin
                    flag($sformatf("expected status %0d data %h count %0d, got %0d %h %0d",
                                   want.status, want.read_data, want.count,
                                   got.status, got.read_data, got.count));
                end
            end
        endfunction

        function bit failed();
            return mismatches != 0 || pending_answers.size() != 0;
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ple_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata;

    list_mirror mirror = new();
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         quiet_cycles = 0;
    bit         growing = 1'b1;

    positional_list_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mirror.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_cmd(input cmd_t op, input where_t loc,
                            input pos_t idx, input logic [ple_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ple_pkg::S_TDATA_W-41){1'b0}}, value, idx, loc, op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        mirror.note_command(s_tdata);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (mirror.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int items, input int tx_pct, input int rx_pct);
        int                          n;
        int                          roll;
        int                          fill_now;
        int                          limit;
        cmd_t                        op;
        where_t                      loc;
        pos_t                        idx;
        logic [ple_pkg::VALUE_W-1:0] value;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (n = 0; n < items; n++) begin
            fill_now = mirror.fill;
            if (fill_now == 0) begin
                growing = 1'b1;
            end else if (fill_now == LIST_DEPTH) begin
                growing = 1'b0;
            end else if ($urandom_range(99) < 3) begin
                growing = !growing;
            end
            roll  = $urandom_range(99);
            loc   = where_t'($urandom_range(2));
            value = ($urandom_range(9) == 0) ? {ple_pkg::VALUE_W{$urandom_range(1) == 1}}
                                             : $urandom;
            if (roll < 6) begin
                // noise: any code, any position
                op  = cmd_t'($urandom_range(3));
                loc = where_t'($urandom_range(3));
                idx = pos_t'($urandom_range(31));
            end else if (roll < 30) begin
                op  = ple_pkg::CMD_READ;
                idx = pos_t'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                      : $urandom_range(fill_now));
            end else begin
                op    = (($urandom_range(99) < 75) == growing) ? ple_pkg::CMD_INSERT
                                                               : ple_pkg::CMD_DELETE;
                limit = (op == ple_pkg::CMD_INSERT) ? fill_now + 1 : fill_now;
                idx   = pos_t'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                        : $urandom_range(limit, 1));
            end
            send_cmd(op, loc, idx, value);
        end
        drain();
    endtask

    initial begin
        int k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 32;
        rx_idle_pct = 74;

        // empty list corner cases
        send_cmd(ple_pkg::CMD_DELETE, ple_pkg::WHERE_FRONT, 5'd0, 32'h0);
        send_cmd(ple_pkg::CMD_READ, ple_pkg::WHERE_FRONT, 5'd0, 32'h0);
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_AT, 5'd0, 32'h1234_5678);
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_AT, 5'd2, 32'h1234_5678);
        // front, back and middle inserts, unused codes and reads
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_FRONT, 5'd0, 32'h0000_0000);
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_BACK, 5'd0, 32'hFFFF_FFFF);
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_AT, 5'd2, 32'hA5A5_5A5A);
        send_cmd(ple_pkg::CMD_INSERT, WHERE_UNUSED, 5'd1, 32'hDEAD_BEEF);
        send_cmd(CMD_UNUSED, WHERE_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_cmd(ple_pkg::CMD_READ, ple_pkg::WHERE_FRONT, 5'd1, 32'h0);
        send_cmd(ple_pkg::CMD_READ, ple_pkg::WHERE_FRONT, 5'd31, 32'h0);
        // fill to the brim
        for (k = 0; k < LIST_DEPTH - 3; k++) begin
            send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_AT,
                     pos_t'($urandom_range(mirror.fill + 1, 1)), $urandom);
        end
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_BACK, 5'd0, 32'h0BAD_F00D);
        send_cmd(ple_pkg::CMD_INSERT, ple_pkg::WHERE_AT, 5'd0, 32'h0BAD_F00D);
        send_cmd(ple_pkg::CMD_READ, ple_pkg::WHERE_FRONT, 5'd15, 32'h0);
        send_cmd(ple_pkg::CMD_READ, ple_pkg::WHERE_FRONT, 5'd16, 32'h0);
        // deletes, bad and good
        send_cmd(ple_pkg::CMD_DELETE, ple_pkg::WHERE_AT, 5'd17, 32'h0);
        send_cmd(ple_pkg::CMD_DELETE, WHERE_UNUSED, 5'd1, 32'h0);
        send_cmd(ple_pkg::CMD_DELETE, ple_pkg::WHERE_FRONT, 5'd0, 32'h0);
        send_cmd(ple_pkg::CMD_DELETE, ple_pkg::WHERE_BACK, 5'd0, 32'h0);
        send_cmd(ple_pkg::CMD_DELETE, ple_pkg::WHERE_AT, 5'd7, 32'h0);
        drain();

        run_phase(170, 32, 74);
        run_phase(170, 74, 32);
        run_phase(160, 0, 0);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mirror.failed()) begin
            $display("%0d mismatches, %0d results outstanding",
                     mirror.mismatches, mirror.pending());
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

endmodule
